[rtl/core/double_ended_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_top_macros
// assertion macros of the deque top
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// shared constants and types of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DQ_CAPACITY = 16;
   localparam int WORD_W      = 32;
   localparam int OP_W        = 3;
   localparam int ST_W        = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

   // per-item info carried from the index unit to the result stage
   typedef struct packed {
      logic [ST_W-1:0] status;
      logic            is_empty;
      logic            fwd_front;
      logic            fwd_back;
   } dq_tag_type;

endpackage

[rtl/core/dq_req_if.sv]
// ----------------------------------------------------------------------------
// dq_req_if
// operation channel of the deque
// ----------------------------------------------------------------------------
interface dq_req_if;
   logic                              valid;
   logic                              ready;
   logic [dq_pkg::OP_W-1:0]           opcode;
   logic signed [dq_pkg::WORD_W-1:0]  push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

[rtl/core/dq_rsp_if.sv]
// ----------------------------------------------------------------------------
// dq_rsp_if
// result channel of the deque
// ----------------------------------------------------------------------------
interface dq_rsp_if #(
   parameter int CNT_W = $clog2(dq_pkg::DQ_CAPACITY + 1)
);
   logic                              valid;
   logic                              ready;
   logic signed [dq_pkg::WORD_W-1:0]  front_value;
   logic signed [dq_pkg::WORD_W-1:0]  back_value;
   logic [CNT_W-1:0]                  item_count;
   logic                              is_empty;
   logic [dq_pkg::ST_W-1:0]           status;

   modport source (output valid, output front_value, output back_value,
                   output item_count, output is_empty, output status, input ready);
   modport sink   (input valid, input front_value, input back_value,
                   input item_count, input is_empty, input status, output ready);
endinterface

[rtl/core/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded deque of signed words in a circular ram
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the result side keeps up; its result
// passes the registered read of the store ram (both ends read at once, the
// pushed word forwarded) and then the result register. A push on a full deque
// and a pop on an empty one leave the contents unchanged and report it in
// status; an empty deque reports -1 at both ends. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top #(
   parameter int  CAPACITY = dq_pkg::DQ_CAPACITY,
   localparam int IDX_W    = $clog2(CAPACITY),
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req_chan,
   dq_rsp_if.source rsp_chan
);

   logic                      adv;
   logic                      s2_valid;
   dq_pkg::dq_tag_type        s2_tag;
   logic [CNT_W-1:0]          s2_count;
   logic [dq_pkg::WORD_W-1:0] s2_fwd_value;
   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   logic [dq_pkg::WORD_W-1:0] ram_wr_data;
   logic                      ram_rd_en;
   logic [IDX_W-1:0]          ram_rd_front;
   logic [IDX_W-1:0]          ram_rd_back;
   logic [dq_pkg::WORD_W-1:0] ram_rd_data_a;
   logic [dq_pkg::WORD_W-1:0] ram_rd_data_b;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::WORD_W-1:0] front_ff, front_in;
   logic [dq_pkg::WORD_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0]          count_ff;
   logic                      empty_ff;
   logic [dq_pkg::ST_W-1:0]   status_ff;

   dq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .adv          (adv),
      .s2_valid     (s2_valid),
      .s2_tag       (s2_tag),
      .s2_count     (s2_count),
      .s2_fwd_value (s2_fwd_value),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_front (ram_rd_front),
      .ram_rd_back  (ram_rd_back)
   );

   dq_ram #(
      .WIDTH (dq_pkg::WORD_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_front),
      .rd_addr_b (ram_rd_back),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   assign adv = s2_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (s2_tag.is_empty) begin
         front_in = '1;
         back_in  = '1;
      end else begin
         front_in = s2_tag.fwd_front ? s2_fwd_value : ram_rd_data_a;
         back_in  = s2_tag.fwd_back  ? s2_fwd_value : ram_rd_data_b;
      end
   end

   assign rsp_valid_in = adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff  <= front_in;
         back_ff   <= back_in;
         count_ff  <= s2_count;
         empty_ff  <= s2_tag.is_empty;
         status_ff <= s2_tag.status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.front_value = front_ff;
   assign rsp_chan.back_value  = back_ff;
   assign rsp_chan.item_count  = count_ff;
   assign rsp_chan.is_empty    = empty_ff;
   assign rsp_chan.status      = status_ff;

   `DQ_ASSERT_NOW(a_no_accept_on_stall, clock, reset, req_chan.valid && req_chan.ready,
                  !s2_valid || adv, "item accepted while read stage is stalled")
   `DQ_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_chan.valid && req_chan.ready,
                   s2_valid, "accepted item missing from read stage")
   `DQ_ASSERT_NOW(a_empty_count, clock, reset, rsp_chan.valid,
                  rsp_chan.is_empty == (rsp_chan.item_count == '0),
                  "empty flag disagrees with count")

endmodule

[rtl/core/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/core/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// front index and count, store addressing and the read stage
// ----------------------------------------------------------------------------
module dq_ctrl #(
   parameter int  CAPACITY = dq_pkg::DQ_CAPACITY,
   localparam int IDX_W    = $clog2(CAPACITY),
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   dq_req_if.sink                      req_chan,
   input  logic                        adv,
   output logic                        s2_valid,
   output dq_pkg::dq_tag_type          s2_tag,
   output logic [CNT_W-1:0]            s2_count,
   output logic [dq_pkg::WORD_W-1:0]   s2_fwd_value,
   output logic                        ram_wr_en,
   output logic [IDX_W-1:0]            ram_wr_addr,
   output logic [dq_pkg::WORD_W-1:0]   ram_wr_data,
   output logic                        ram_rd_en,
   output logic [IDX_W-1:0]            ram_rd_front,
   output logic [IDX_W-1:0]            ram_rd_back
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   logic [IDX_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      s2_valid_ff, s2_valid_in;
   dq_pkg::dq_tag_type        tag_ff, tag_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic [dq_pkg::WORD_W-1:0] fwd_ff;

   logic                      accept;
   logic                      full;
   logic                      empty;
   logic [IDX_W-1:0]          front_dec;
   logic [IDX_W-1:0]          front_inc;
   logic [IDX_W-1:0]          back_addr;
   logic                      wr_req;
   logic [IDX_W-1:0]          wr_addr;
   logic [dq_pkg::ST_W-1:0]   status;

   // (a + b) modulo capacity, with a below capacity and b at most capacity - 1
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + (IDX_W+1)'(b);
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      status   = dq_pkg::ST_OK;
      wr_req   = 1'b0;
      wr_addr  = front_dec;
      case (req_chan.opcode)
         dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = dq_pkg::ST_OVERFLOW;
            end else begin
               front_in = front_dec;
               count_in = count_ff + 1'b1;
               wr_req   = 1'b1;
               wr_addr  = front_dec;
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = dq_pkg::ST_OVERFLOW;
            end else begin
               count_in = count_ff + 1'b1;
               wr_req   = 1'b1;
               wr_addr  = wrap_add(front_ff, count_ff);
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status = dq_pkg::ST_OK;
         end
      endcase
   end

   assign back_addr = wrap_add(front_in, count_in - 1'b1);

   assign req_chan.ready = !s2_valid_ff || adv;
   assign accept         = req_chan.valid && req_chan.ready;

   // the ram returns old data on a same-cycle write, so the pushed word is forwarded
   always_comb begin
      tag_in.status    = status;
      tag_in.is_empty  = (count_in == '0);
      tag_in.fwd_front = wr_req && (wr_addr == front_in);
      tag_in.fwd_back  = wr_req && (wr_addr == back_addr);
   end

   assign s2_valid_in = accept ? 1'b1 : (adv ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= tag_in;
         cnt_ff <= count_in;
         fwd_ff <= req_chan.push_value;
      end
   end

   assign ram_wr_en    = accept && wr_req;
   assign ram_wr_addr  = wr_addr;
   assign ram_wr_data  = req_chan.push_value;
   assign ram_rd_en    = accept;
   assign ram_rd_front = front_in;
   assign ram_rd_back  = back_addr;

   assign s2_valid     = s2_valid_ff;
   assign s2_tag       = tag_ff;
   assign s2_count     = cnt_ff;
   assign s2_fwd_value = fwd_ff;

endmodule
